// ===== rtl/indexed_list_engine_top_assert.svh =====
// Assertion macros shared by the indexed list engine RTL.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef INDEXED_LIST_ENGINE_TOP_ASSERT_SVH
`define INDEXED_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ILE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ILE_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ILE_ASSERT(label, prop, msg)
`define ILE_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/ile_pkg.sv =====
// Shared types and constants of the indexed list engine.
// Used by the list cell, the priority encoder and the top level.
package ile_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int POS_W       = 5;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_SEARCH  = 3'd2,
        CMD_SELECT  = 3'd3,
        CMD_REPLACE = 3'd4
    } ile_cmd_t;

    typedef struct packed {
        logic                  do_insert;
        logic                  do_remove;
        logic                  do_replace;
        logic [CMP_W-1:0]      pos;
        logic [CMP_W-1:0]      count;
        logic [DATA_WIDTH-1:0] data;
    } ile_bcast_t;

endpackage

// ===== rtl/ile_cell.sv =====
// One list entry: holds a value, shifts with its neighbors and reports a match.
// Depends on ile_pkg.
module ile_cell
    import ile_pkg::*;
(
    input  logic                  clk,
    input  ile_bcast_t            bcast,
    input  logic [CMP_W-1:0]      idx,
    input  logic [DATA_WIDTH-1:0] left_val,
    input  logic [DATA_WIDTH-1:0] right_val,
    output logic [DATA_WIDTH-1:0] val,
    output logic                  hit
);

    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (bcast.do_insert)
        begin
            if (idx > bcast.pos)
            begin
                val_next = left_val;
            end
            else if (idx == bcast.pos)
            begin
                val_next = bcast.data;
            end
        end
        else if (bcast.do_remove)
        begin
            if (idx >= bcast.pos)
            begin
                val_next = right_val;
            end
        end
        else if (bcast.do_replace)
        begin
            if (idx == bcast.pos)
            begin
                val_next = bcast.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign hit = (val_reg == bcast.data) && (idx < bcast.count);

endmodule

// ===== rtl/ile_prienc.sv =====
// Lowest-index priority encoder over the registered match vector of the cells.
// Depends on ile_pkg.
module ile_prienc
    import ile_pkg::*;
(
    input  logic [DEPTH-1:0] hits,
    input  logic [CNT_W-1:0] count,
    output logic [CNT_W-1:0] found
);

    always_comb
    begin
        found = count;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                found = CNT_W'(i);
            end
        end
    end

endmodule

// ===== rtl/indexed_list_engine_top.sv =====
// Top level of the indexed list engine: command decode, the row of list cells,
// the result stage and the output register.
// Depends on ile_pkg, ile_cell, ile_prienc and indexed_list_engine_top_assert.svh.
//
// Usage: each command word enters on the slave stream. tuser carries the
// command code (insert, remove, search, select, replace); tdata carries the
// position and the data value. Each command returns exactly one result word
// on the master stream with ok, the selected value, the search position,
// the entry count and the full and empty flags.
// An accepted command passes the middle stage and the output register before its
// result word is valid. The list is a row of cells that shift, overwrite and
// compare in the acceptance cycle; the match vector is encoded in the following
// cycle. A new command word is accepted every cycle while the result side keeps
// up, so throughput is one word per cycle.
// Reset empties the list; the cells themselves are not cleared since only
// entries below the count are ever read. When the receiver stalls, the
// result word holds, one more command completes into the middle stage, and
// then tready drops until the master side drains.
`include "indexed_list_engine_top_assert.svh"
module indexed_list_engine_top
    import ile_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // position[4:0], data_in[36:5], zero fill above.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command[2:0].
    input  logic [2:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // ok[0], data_out[32:1], found_at[37:33], entries_used[42:38],
    // is_full[43], is_empty[44], zero fill above.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                  in_acc;
    ile_cmd_t              cmd;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      count_c;
    logic [DATA_WIDTH-1:0] data_w;
    logic                  pos_lt;
    logic                  pos_le;
    logic                  not_full;
    logic                  ok_c;
    logic                  ins_c;
    logic                  rem_c;
    logic                  rep_c;
    logic                  sel_c;
    logic                  srch_c;
    ile_bcast_t            bcast;

    logic [CNT_W-1:0]      fill_count_reg;
    logic [CNT_W-1:0]      fill_count_next;

    logic [DATA_WIDTH-1:0] vals [DEPTH];
    logic [DEPTH-1:0]      hits;
    logic [DATA_WIDTH-1:0] rd_c;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_adv;
    logic                  s1_ok_reg;
    logic                  s1_search_reg;
    logic [DATA_WIDTH-1:0] s1_rd_reg;
    logic [DEPTH-1:0]      s1_hits_reg;
    logic [CNT_W-1:0]      s1_count_reg;
    logic [CNT_W-1:0]      found;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg;
    logic [OUT_TDATA_W-1:0] out_tdata_next;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cmd      = ile_cmd_t'(s_axis_tuser);
    assign pos_c    = CMP_W'(s_axis_tdata[POS_W-1:0]);
    assign data_w   = DATA_WIDTH'(s_axis_tdata[36:5]);
    assign count_c  = CMP_W'(fill_count_reg);
    assign pos_lt   = pos_c < count_c;
    assign pos_le   = pos_c <= count_c;
    assign not_full = fill_count_reg != CNT_W'(DEPTH);

    always_comb
    begin
        ok_c   = 1'b0;
        ins_c  = 1'b0;
        rem_c  = 1'b0;
        rep_c  = 1'b0;
        sel_c  = 1'b0;
        srch_c = 1'b0;
        case (cmd)
            CMD_INSERT:
            begin
                ok_c  = not_full && pos_le;
                ins_c = ok_c;
            end
            CMD_REMOVE:
            begin
                ok_c  = pos_lt;
                rem_c = ok_c;
            end
            CMD_SEARCH:
            begin
                ok_c   = 1'b1;
                srch_c = 1'b1;
            end
            CMD_SELECT:
            begin
                ok_c  = pos_lt;
                sel_c = ok_c;
            end
            CMD_REPLACE:
            begin
                ok_c  = pos_lt;
                rep_c = ok_c;
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    assign bcast.do_insert  = in_acc && ins_c;
    assign bcast.do_remove  = in_acc && rem_c;
    assign bcast.do_replace = in_acc && rep_c;
    assign bcast.pos        = pos_c;
    assign bcast.count      = count_c;
    assign bcast.data       = data_w;

    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (bcast.do_insert)
        begin
            fill_count_next = fill_count_reg + 1'b1;
        end
        else if (bcast.do_remove)
        begin
            fill_count_next = fill_count_reg - 1'b1;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_val;
        logic [DATA_WIDTH-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = vals[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid_r
            assign right_val = vals[i+1];
        end

        ile_cell u_cell (
            .clk       (clk),
            .bcast     (bcast),
            .idx       (CMP_W'(i)),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (vals[i]),
            .hit       (hits[i])
        );
    end

    assign rd_c = sel_c ? vals[pos_c[IDX_W-1:0]] : '0;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ok_reg     <= ok_c;
            s1_search_reg <= srch_c;
            s1_rd_reg     <= rd_c;
            s1_hits_reg   <= hits;
            s1_count_reg  <= fill_count_next;
        end
    end

    ile_prienc u_prienc (
        .hits  (s1_hits_reg),
        .count (s1_count_reg),
        .found (found)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_tdata_next = {
        3'b000,
        (s1_count_reg == '0),
        (s1_count_reg == CNT_W'(DEPTH)),
        POS_W'(s1_count_reg),
        s1_search_reg ? POS_W'(found) : POS_W'(0),
        32'(s1_rd_reg),
        s1_ok_reg
    };

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_tdata_reg <= out_tdata_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;

    `ILE_NEVER(a_count_range, fill_count_reg > CNT_W'(DEPTH), "entry count exceeds depth")
    `ILE_ASSERT(a_full_insert_holds, (in_acc && cmd == CMD_INSERT && !not_full) |=> (fill_count_reg == $past(fill_count_reg)), "insert into full list changed count")
    `ILE_ASSERT(a_remove_dec, bcast.do_remove |=> (fill_count_reg == $past(fill_count_reg) - 1'b1), "remove did not decrement count")
    `ILE_ASSERT(a_s1_hold, (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_hits_reg)), "middle stage lost its word")
    `ILE_NEVER(a_accept_on_stall, in_acc && s1_valid_reg && !s1_adv, "word accepted over a stalled middle stage")

endmodule

// ===== bench/indexed_list_engine_top_tb.sv =====
// Self-checking testbench for indexed_list_engine_top, the ordered value list engine.
// It drives command words on the slave stream and checks each result word on the
// master stream against a predictor of the list. It depends on ile_pkg and the RTL only.
`timescale 1ns / 100ps
module indexed_list_engine_top_tb;
    import ile_pkg::*;

    localparam int         CYCLE_LIMIT = 100000;
    localparam int         IDLE_PCT    = 19;
    localparam logic [2:0] CMD_BAD_LO  = 3'd5;
    localparam logic [2:0] CMD_BAD_MID = 3'd6;
    localparam logic [2:0] CMD_BAD_HI  = 3'd7;

    typedef struct packed {
        logic                  ok;
        logic [DATA_WIDTH-1:0] data_out;
        logic [POS_W-1:0]      found_at;
        logic [CNT_W-1:0]      entries_used;
        logic                  is_full;
        logic                  is_empty;
    } list_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [2:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [DATA_WIDTH-1:0] list_vals [DEPTH];
    int unsigned           list_len = 0;
    list_result_t          expected_results [$];
    int                    errors = 0;
    bit                    steady = 1'b0;
    int                    stall_request = 0;
    int                    stall_left = 0;

    indexed_list_engine_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic list_result_t apply_command(input logic [2:0] cmd,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_WIDTH-1:0] value);
        list_result_t res;
        int           p;
        bit           hit;
        res = '0;
        p   = pos;
        hit = 1'b0;
        case (cmd)
            CMD_INSERT:
            begin
                if (list_len < DEPTH && p <= list_len)
                begin
                    for (int i = list_len; i > p; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[p] = value;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (p < list_len)
                begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            CMD_SEARCH:
            begin
                res.found_at = POS_W'(list_len);
                for (int i = 0; i < list_len; i++)
                begin
                    if (!hit && list_vals[i] == value)
                    begin
                        res.found_at = POS_W'(i);
                        hit = 1'b1;
                    end
                end
                res.ok = 1'b1;
            end
            CMD_SELECT:
            begin
                if (p < list_len)
                begin
                    res.data_out = list_vals[p];
                    res.ok = 1'b1;
                end
            end
            CMD_REPLACE:
            begin
                if (p < list_len)
                begin
                    list_vals[p] = value;
                    res.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.entries_used = CNT_W'(list_len);
        res.is_full      = (list_len == DEPTH);
        res.is_empty     = (list_len == 0);
        return res;
    endfunction

    task automatic send_word(input logic [2:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [DATA_WIDTH-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_TDATA_W - DATA_WIDTH - POS_W){1'b0}}, value, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(apply_command(cmd, pos, value));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_side
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with no expectation waiting: %0h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("ok", want.ok, m_axis_tdata[0]);
                check_field("data_out", want.data_out, m_axis_tdata[32:1]);
                check_field("found_at", want.found_at, m_axis_tdata[37:33]);
                check_field("entries_used", want.entries_used, m_axis_tdata[42:38]);
                check_field("is_full", want.is_full, m_axis_tdata[43]);
                check_field("is_empty", want.is_empty, m_axis_tdata[44]);
            end
        end
        if (stall_request > 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic test_empty_list();
        send_word(CMD_REMOVE, 5'd0, 32'h1234_5678);
        send_word(CMD_SELECT, 5'd0, 32'h0);
        send_word(CMD_REPLACE, 5'd0, 32'hDEAD_BEEF);
        send_word(CMD_SEARCH, 5'd0, 32'h0);
        send_word(CMD_INSERT, 5'd1, 32'h1111_1111);
        send_word(CMD_BAD_LO, 5'd0, 32'h0);
    endtask

    task automatic test_basic_commands();
        send_word(CMD_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 5'd0, 32'h0000_0000);
        send_word(CMD_INSERT, 5'd2, 32'hA5A5_A5A5);
        send_word(CMD_INSERT, 5'd5, 32'h5A5A_5A5A);
        send_word(CMD_SEARCH, 5'd0, 32'h0000_0000);
        send_word(CMD_SEARCH, 5'd31, 32'h1234_5678);
        send_word(CMD_SELECT, 5'd1, 32'h0);
        send_word(CMD_REPLACE, 5'd2, 32'h0000_0000);
        send_word(CMD_SEARCH, 5'd0, 32'h0000_0000);
        send_word(CMD_SELECT, 5'd3, 32'h0);
        send_word(CMD_SELECT, 5'd31, 32'hFFFF_FFFF);
        send_word(CMD_REMOVE, 5'd1, 32'h0);
        send_word(CMD_REMOVE, 5'd1, 32'h0);
        send_word(CMD_BAD_MID, 5'd16, 32'hFFFF_FFFF);
        send_word(CMD_BAD_HI, 5'd31, 32'h8000_0001);
        send_word(CMD_SELECT, 5'd0, 32'h0);
    endtask

    task automatic test_fill_under_stall();
        stall_request = 80;
        steady = 1'b1;
        for (int k = 0; k < 20; k++)
            send_word(CMD_INSERT, POS_W'($urandom_range(0, list_len)), $urandom());
        send_word(CMD_INSERT, 5'd16, 32'hCAFE_0001);
        send_word(CMD_SELECT, 5'd15, 32'h0);
        send_word(CMD_SELECT, 5'd16, 32'h0);
        send_word(CMD_SEARCH, 5'd0, list_vals[DEPTH-1]);
        send_word(CMD_REMOVE, 5'd15, 32'h0);
        send_word(CMD_REMOVE, 5'd0, 32'h0);
        steady = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [2:0]            cmd;
        logic [POS_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] value;
        int                    pick;
        bit                    growing;
        growing = 1'b1;
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                growing = !growing;
            steady = (k >= 300 && k < 450);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
            else if (pick < (growing ? 43 : 18))
                cmd = CMD_INSERT;
            else if (pick < 58)
                cmd = CMD_REMOVE;
            else if (pick < 73)
                cmd = CMD_SEARCH;
            else if (pick < 87)
                cmd = CMD_SELECT;
            else
                cmd = CMD_REPLACE;
            if ($urandom_range(0, 99) < 15)
                pos = POS_W'($urandom_range(0, 31));
            else if (cmd == CMD_INSERT)
                pos = POS_W'($urandom_range(0, list_len));
            else if (list_len == 0)
                pos = '0;
            else
                pos = POS_W'($urandom_range(0, list_len - 1));
            pick = $urandom_range(0, 9);
            if (list_len != 0 && pick < 4)
                value = list_vals[$urandom_range(0, list_len - 1)];
            else if (pick < 6)
                value = DATA_WIDTH'($urandom_range(0, 3));
            else
                value = $urandom();
            send_word(cmd, pos, value);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_commands();
        test_fill_under_stall();
        test_random_traffic(750);
        wait_drain();
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== indexed_list_engine_top.f =====
+incdir+rtl
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/ile_prienc.sv
rtl/indexed_list_engine_top.sv
bench/indexed_list_engine_top_tb.sv
